/* hdl/rc4sc_pkg.sv */
// ----------------------------------------------------------------------------
// rc4sc_pkg
// shared types and command codes for the rc4 stream cipher engine
// ----------------------------------------------------------------------------
package rc4sc_pkg;

	localparam int OP_W = 4;

	localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
	localparam logic [OP_W-1:0] OP_CAPTURE = 4'd1;
	localparam logic [OP_W-1:0] OP_KEY     = 4'd2;
	localparam logic [OP_W-1:0] OP_INIT    = 4'd3;
	localparam logic [OP_W-1:0] OP_K0      = 4'd4;
	localparam logic [OP_W-1:0] OP_K1      = 4'd5;
	localparam logic [OP_W-1:0] OP_K2      = 4'd6;
	localparam logic [OP_W-1:0] OP_K3      = 4'd7;
	localparam logic [OP_W-1:0] OP_RDI     = 4'd8;
	localparam logic [OP_W-1:0] OP_RDJ     = 4'd9;
	localparam logic [OP_W-1:0] OP_SWP     = 4'd10;
	localparam logic [OP_W-1:0] OP_FIN     = 4'd11;
	localparam logic [OP_W-1:0] OP_PASS    = 4'd12;

	localparam int ACT_KEY  = 0;
	localparam int ACT_DATA = 1;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic keyed;
		logic key_last;
		logic n_last;
		logic out_free;
	} sts_t;

endpackage

/* hdl/rc4sc_ctrl.sv */
// ----------------------------------------------------------------------------
// rc4sc_ctrl
// sequencer for key load, key schedule and per-byte keystream generation
// ----------------------------------------------------------------------------
module rc4sc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_action,
	input  rc4sc_pkg::sts_t sts,
	output rc4sc_pkg::cmd_t cmd,
	output logic          in_ready
);
	import rc4sc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_KEY  = 4'd1;
	localparam logic [3:0] ST_INIT = 4'd2;
	localparam logic [3:0] ST_K0   = 4'd3;
	localparam logic [3:0] ST_K1   = 4'd4;
	localparam logic [3:0] ST_K2   = 4'd5;
	localparam logic [3:0] ST_K3   = 4'd6;
	localparam logic [3:0] ST_RDI  = 4'd7;
	localparam logic [3:0] ST_RDJ  = 4'd8;
	localparam logic [3:0] ST_SWP  = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;
	localparam logic [3:0] ST_PASS = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NOP;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
					if (in_action == 1'(ACT_KEY))
						state_nxt = ST_KEY;
					else if (sts.keyed)
						state_nxt = ST_RDI;
					else
						state_nxt = ST_PASS;
				end
			end
			ST_KEY: begin
				cmd.op    = OP_KEY;
				state_nxt = sts.key_last ? ST_INIT : ST_IDLE;
			end
			ST_INIT: begin
				cmd.op = OP_INIT;
				if (sts.n_last)
					state_nxt = ST_K0;
			end
			ST_K0: begin
				cmd.op    = OP_K0;
				state_nxt = ST_K1;
			end
			ST_K1: begin
				cmd.op    = OP_K1;
				state_nxt = ST_K2;
			end
			ST_K2: begin
				cmd.op    = OP_K2;
				state_nxt = ST_K3;
			end
			ST_K3: begin
				cmd.op    = OP_K3;
				state_nxt = sts.n_last ? ST_IDLE : ST_K0;
			end
			ST_RDI: begin
				cmd.op    = OP_RDI;
				state_nxt = ST_RDJ;
			end
			ST_RDJ: begin
				cmd.op    = OP_RDJ;
				state_nxt = ST_SWP;
			end
			ST_SWP: begin
				cmd.op    = OP_SWP;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.op    = OP_FIN;
					state_nxt = ST_IDLE;
				end
			end
			ST_PASS: begin
				if (sts.out_free) begin
					cmd.op    = OP_PASS;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

/* hdl/rc4sc_dp.sv */
// ----------------------------------------------------------------------------
// rc4sc_dp
// permutation table, key store, index registers and output register
// ----------------------------------------------------------------------------
module rc4sc_dp #(
	parameter int KEY_BYTES_MAX = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rc4sc_pkg::cmd_t cmd,
	input  logic [7:0]      byte_in,
	input  logic            key_last,
	input  logic            data_last,
	output rc4sc_pkg::sts_t sts,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      byte_out,
	output logic            unkeyed,
	output logic            msg_last
);
	import rc4sc_pkg::*;

	localparam int KIW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
	localparam int CW  = $clog2(KEY_BYTES_MAX + 1);

	logic [7:0]     perm_mem [256];
	logic [7:0]     key_mem [KEY_BYTES_MAX];

	logic [7:0]     byte_q;
	logic           klast_q;
	logic           dlast_q;
	logic [CW-1:0]  kcnt_q;
	logic [KIW-1:0] kidx_q;
	logic [7:0]     i_q;
	logic [7:0]     j_q;
	logic [7:0]     n_q;
	logic [7:0]     a_q;
	logic [7:0]     b_q;
	logic           keyed_q;
	logic [7:0]     rdata_q;
	logic [7:0]     krd_q;
	logic           out_valid_q;
	logic [7:0]     byte_out_q;
	logic           unkeyed_q;
	logic           msg_last_q;

	logic           pwe;
	logic [7:0]     pwaddr;
	logic [7:0]     pwdata;
	logic           pre;
	logic [7:0]     praddr;
	logic [7:0]     j_sched;
	logic [7:0]     ks_idx;
	logic [7:0]     ks_byte;
	logic           key_room;
	logic [CW:0]    kidx_inc;
	logic           kidx_wrap;
	logic           out_free;

	assign j_sched   = j_q + rdata_q + krd_q;
	assign ks_idx    = a_q + b_q;
	assign key_room  = kcnt_q < CW'(KEY_BYTES_MAX);
	assign kidx_inc  = (CW+1)'(kidx_q) + 1'b1;
	assign kidx_wrap = kidx_inc >= {1'b0, kcnt_q};
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (ks_idx == j_q)
			ks_byte = a_q;
		else if (ks_idx == i_q)
			ks_byte = b_q;
		else
			ks_byte = rdata_q;
	end

	always_comb begin
		pwe    = 1'b0;
		pwaddr = n_q;
		pwdata = n_q;
		pre    = 1'b0;
		praddr = n_q;
		case (cmd.op)
			OP_INIT: begin
				pwe = 1'b1;
			end
			OP_K0: begin
				pre = 1'b1;
			end
			OP_K1: begin
				pre    = 1'b1;
				praddr = j_sched;
			end
			OP_K2: begin
				pwe    = 1'b1;
				pwdata = rdata_q;
			end
			OP_K3: begin
				pwe    = 1'b1;
				pwaddr = j_q;
				pwdata = a_q;
			end
			OP_RDI: begin
				pre    = 1'b1;
				praddr = i_q + 8'd1;
			end
			OP_RDJ: begin
				pre    = 1'b1;
				praddr = j_q + rdata_q;
			end
			OP_SWP: begin
				pwe    = 1'b1;
				pwaddr = i_q;
				pwdata = rdata_q;
				pre    = 1'b1;
				praddr = a_q + rdata_q;
			end
			OP_FIN: begin
				pwe    = 1'b1;
				pwaddr = j_q;
				pwdata = a_q;
			end
			default: begin
				pwe = 1'b0;
			end
		endcase
	end

	// permutation table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (pwe)
			perm_mem[pwaddr] <= pwdata;
		if (pre)
			rdata_q <= perm_mem[praddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_KEY && key_room)
			key_mem[kcnt_q[KIW-1:0]] <= byte_q;
		if (cmd.op == OP_K0)
			krd_q <= key_mem[kidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q      <= '0;
			kidx_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_KEY: begin
					if (key_room)
						kcnt_q <= kcnt_q + 1'b1;
				end
				OP_INIT: begin
					j_q    <= '0;
					kidx_q <= '0;
				end
				OP_K1: begin
					j_q <= j_sched;
				end
				OP_K3: begin
					kidx_q <= kidx_wrap ? '0 : kidx_inc[KIW-1:0];
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						kcnt_q  <= '0;
						keyed_q <= 1'b1;
					end
				end
				OP_RDI: begin
					i_q <= i_q + 8'd1;
				end
				OP_RDJ: begin
					j_q <= j_q + rdata_q;
				end
				default: begin
					kcnt_q <= kcnt_q;
				end
			endcase
			if (cmd.op == OP_FIN || cmd.op == OP_PASS)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				byte_q  <= byte_in;
				klast_q <= key_last;
				dlast_q <= data_last;
			end
			OP_KEY: begin
				n_q <= '0;
			end
			OP_INIT: begin
				n_q <= n_q + 8'd1;
			end
			OP_K1: begin
				a_q <= rdata_q;
			end
			OP_K3: begin
				n_q <= n_q + 8'd1;
			end
			OP_RDJ: begin
				a_q <= rdata_q;
			end
			OP_SWP: begin
				b_q <= rdata_q;
			end
			OP_FIN: begin
				byte_out_q <= byte_q ^ ks_byte;
				unkeyed_q  <= 1'b0;
				msg_last_q <= dlast_q;
			end
			OP_PASS: begin
				byte_out_q <= byte_q;
				unkeyed_q  <= 1'b1;
				msg_last_q <= dlast_q;
			end
			default: begin
				byte_q <= byte_q;
			end
		endcase
	end

	assign sts.keyed    = keyed_q;
	assign sts.key_last = klast_q;
	assign sts.n_last   = (n_q == 8'hFF);
	assign sts.out_free = out_free;

	assign out_valid = out_valid_q;
	assign byte_out  = byte_out_q;
	assign unkeyed   = unkeyed_q;
	assign msg_last  = msg_last_q;

endmodule

/* hdl/rc4_stream_cipher.sv */
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// rc4 (arcfour) cipher engine with a stream input for key and data bytes
// ----------------------------------------------------------------------------
// Key bytes (tuser[0] = 0) fill a key store of KEY_BYTES_MAX bytes; the one
// with tuser[1] set starts the key schedule. Data bytes (tuser[0] = 1) come
// back XORed with the keystream, tlast echoed; before the first schedule they
// pass unchanged with m_tuser set. The 256-entry table has one write and one
// read port, so the input is held while a byte is worked on: a keyed data
// byte goes through the read-i, read-j, swap and finish states, an unkeyed
// data byte the pass state, a key byte the key-store state, and a final key
// byte the key schedule (identity load, then steps K0 to K3 per entry). A
// finished result waits in the output register as the next byte is taken.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
	parameter int KEY_BYTES_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // byte_in
	input  logic [1:0] s_tuser,   // action, key_last
	input  logic       s_tlast,   // data_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // byte_out
	output logic [0:0] m_tuser,   // unkeyed
	output logic       m_tlast    // msg_last
);
	import rc4sc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rc4sc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser[0]),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_tready)
	);

	rc4sc_dp #(
		.KEY_BYTES_MAX (KEY_BYTES_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.byte_in   (s_tdata),
		.key_last  (s_tuser[1]),
		.data_last (s_tlast),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.byte_out  (m_tdata),
		.unkeyed   (m_tuser[0]),
		.msg_last  (m_tlast)
	);

endmodule

/* hdl/rc4sc_chk.sv */
// ----------------------------------------------------------------------------
// rc4sc_chk
// port-level checks for the rc4 stream cipher engine
// ----------------------------------------------------------------------------
module rc4sc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// one transaction in flight at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// final key byte blocks input for the schedule
	a_sched_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] && s_tuser[1]
		|=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input reopened during key schedule");

	// no result appears in the cycle right after a transaction
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result raised too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind rc4_stream_cipher rc4sc_chk u_chk (.*);

/* bench/rc4_cipher_checker.sv */
// ----------------------------------------------------------------------------
// rc4_cipher_checker
// watches both stream channels of the rc4 engine, keeps its own copy of the
// cipher state, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module rc4_cipher_checker #(
	parameter int KEY_CAP = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // byte_in
	input  logic [1:0] s_tuser,   // action, key_last
	input  logic       s_tlast,   // data_last
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // byte_out
	input  logic [0:0] m_tuser,   // unkeyed
	input  logic       m_tlast,   // msg_last
	output int         errors,
	output int         outstanding,
	output int         checked,
	output int         schedules
);
	timeunit 1ns;
	timeprecision 1ps;

	import rc4sc_pkg::*;

	typedef struct {
		logic [7:0] byte_out;
		logic       unkeyed;
		logic       msg_last;
	} cipher_result_t;

	cipher_result_t expected_out[$];

	logic [7:0] perm [256];
	logic [7:0] ptr_i = '0;
	logic [7:0] ptr_j = '0;
	logic [7:0] key_buf [KEY_CAP];
	int         key_fill = 0;
	bit         have_key = 1'b0;

	initial begin
		errors = 0;
		outstanding = 0;
		checked = 0;
		schedules = 0;
	end

	function automatic void run_key_schedule();
		int         n;
		int         k;
		int         len;
		logic [7:0] jj;
		logic [7:0] t;
		len = (key_fill == 0) ? 1 : key_fill;
		for (n = 0; n < 256; n++)
			perm[n] = 8'(n);
		jj = '0;
		k = 0;
		for (n = 0; n < 256; n++) begin
			t = perm[n];
			jj = jj + t + key_buf[k];
			perm[n] = perm[jj];
			perm[jj] = t;
			k++;
			if (k >= len)
				k = 0;
		end
		ptr_i = '0;
		ptr_j = '0;
		key_fill = 0;
		have_key = 1'b1;
		schedules++;
	endfunction

	function automatic logic [7:0] next_keystream();
		logic [7:0] a;
		logic [7:0] b;
		ptr_i = ptr_i + 8'd1;
		a = perm[ptr_i];
		ptr_j = ptr_j + a;
		b = perm[ptr_j];
		perm[ptr_i] = b;
		perm[ptr_j] = a;
		return perm[8'(a + b)];
	endfunction

	function automatic void flag_error(string what);
		errors++;
		if (errors <= 10)
			$display("[%0t] %s", $time, what);
	endfunction

	always @(posedge clk) begin
		cipher_result_t want;
		cipher_result_t res;
		if (arst_n) begin
			// results first: a result never belongs to the transaction taken on the same edge
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					flag_error($sformatf("unexpected result: byte %02h unkeyed %0b last %0b",
						m_tdata, m_tuser[0], m_tlast));
				end else begin
					want = expected_out.pop_front();
					if (m_tdata !== want.byte_out || m_tuser[0] !== want.unkeyed ||
					    m_tlast !== want.msg_last)
						flag_error($sformatf(
							"result %0d: expected byte %02h unkeyed %0b last %0b, got %02h %0b %0b",
							checked, want.byte_out, want.unkeyed, want.msg_last,
							m_tdata, m_tuser[0], m_tlast));
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == 1'(ACT_KEY)) begin
					if (key_fill < KEY_CAP) begin
						key_buf[key_fill] = s_tdata;
						key_fill++;
					end
					if (s_tuser[1])
						run_key_schedule();
				end else begin
					res.msg_last = s_tlast;
					if (!have_key) begin
						res.byte_out = s_tdata;
						res.unkeyed = 1'b1;
					end else begin
						res.byte_out = s_tdata ^ next_keystream();
						res.unkeyed = 1'b0;
					end
					expected_out.push_back(res);
				end
			end
			outstanding = expected_out.size();
		end
	end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// stream-level regression of the rc4 cipher engine: directed key and data
// sequences, then random keys and messages under bursty input and a stalling
// output; the checker predicts each result and reports the failures
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4sc_pkg::*;

	localparam int KEY_CAP     = 32;
	localparam int TOTAL_ITEMS = 750;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 1300;
	localparam int CYCLE_LIMIT = 800000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [0:0] m_tuser;
	logic       m_tlast;

	int errors;
	int outstanding;
	int checked;
	int schedules;
	int cycle_count = 0;
	int key_items = 0;
	int data_items = 0;
	int burst_left = 0;
	bit hold_request = 1'b0;

	rc4_stream_cipher #(.KEY_BYTES_MAX(KEY_CAP)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	rc4_cipher_checker #(.KEY_CAP(KEY_CAP)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.errors(errors), .outstanding(outstanding), .checked(checked),
		.schedules(schedules)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one transaction, then a gap when the current burst runs out
	task automatic send_item(input logic act, input logic [7:0] value,
	                         input logic key_last, input logic data_last);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= {key_last, act};
		s_tlast <= data_last;
		do
			@(posedge clk);
		while (!s_tready);
		if (act == 1'(ACT_KEY))
			key_items++;
		else
			data_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(0, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_key(input int len, input bit finish);
		int n;
		for (n = 0; n < len; n++)
			send_item(1'(ACT_KEY), 8'($urandom_range(0, 255)),
				finish && (n == len - 1), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_message(input int len);
		int n;
		for (n = 0; n < len; n++)
			send_item(1'(ACT_DATA), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				(n == len - 1) || ($urandom_range(0, 15) == 0));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// receiver: runs of always-ready, random and patterned stalls, one long hold
	initial begin : receiver
		int mode;
		int run_len;
		int n;
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(1, 40);
			for (n = 0; n < run_len; n++) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (n % 3) != 2;
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int sel;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unkeyed pass-through, key_last ignored on data
		send_item(1'(ACT_DATA), 8'h00, 1'b1, 1'b0);
		send_item(1'(ACT_DATA), 8'hff, 1'b0, 1'b1);
		send_item(1'(ACT_DATA), 8'ha5, 1'b0, 1'b0);
		// partial key, data_last ignored on key bytes
		send_item(1'(ACT_KEY), 8'h00, 1'b0, 1'b1);
		send_item(1'(ACT_DATA), 8'h5a, 1'b0, 1'b1);
		send_item(1'(ACT_KEY), 8'hff, 1'b1, 1'b0);
		send_item(1'(ACT_DATA), 8'h00, 1'b0, 1'b0);
		send_item(1'(ACT_DATA), 8'hff, 1'b1, 1'b0);
		send_item(1'(ACT_DATA), 8'h3c, 1'b0, 1'b0);
		send_item(1'(ACT_DATA), 8'hc3, 1'b0, 1'b1);
		// partial key leaves the stream running
		send_item(1'(ACT_KEY), 8'h80, 1'b0, 1'b0);
		send_item(1'(ACT_DATA), 8'h11, 1'b0, 1'b1);
		send_item(1'(ACT_KEY), 8'h7f, 1'b1, 1'b1);
		send_item(1'(ACT_KEY), 8'hff, 1'b1, 1'b0);
		send_item(1'(ACT_DATA), 8'h00, 1'b0, 1'b0);
		send_item(1'(ACT_DATA), 8'h00, 1'b0, 1'b0);
		send_item(1'(ACT_DATA), 8'h00, 1'b0, 1'b1);
		send_item(1'(ACT_KEY), 8'h00, 1'b1, 1'b0);
		send_item(1'(ACT_DATA), 8'hff, 1'b0, 1'b0);
		send_item(1'(ACT_DATA), 8'h01, 1'b0, 1'b1);
		drain();

		// long receiver hold while a message keeps coming
		hold_request = 1'b1;
		send_message($urandom_range(12, 24));
		send_key(36, 1'b1);
		send_message($urandom_range(4, 16));
		while (key_items + data_items < TOTAL_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 3)
				send_key(($urandom_range(0, 7) == 0) ? $urandom_range(30, 40)
				                                     : $urandom_range(1, 16), 1'b1);
			else if (sel == 3)
				send_key($urandom_range(1, 3), 1'b0);
			send_message($urandom_range(1, 24));
			if ($urandom_range(0, 15) == 0)
				drain();
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d key bytes and %0d data bytes, %0d key schedules",
			key_items, data_items, schedules);
		$display("checked %0d results, %0d failures", checked, errors + outstanding);
		if (errors == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
